[sv/rpu_pkg.sv]
package rpu_pkg;

	// relocation type codes
	localparam logic [3:0] MODE_NONE     = 4'd0;
	localparam logic [3:0] MODE_ABS64    = 4'd1;
	localparam logic [3:0] MODE_ABS32    = 4'd2;
	localparam logic [3:0] MODE_ABS32U   = 4'd3;
	localparam logic [3:0] MODE_PC32     = 4'd4;
	localparam logic [3:0] MODE_PC32PLT  = 4'd5;
	localparam logic [3:0] MODE_PC64     = 4'd6;
	localparam logic [3:0] MODE_GOTPCREL = 4'd7;
	localparam logic [3:0] MODE_ADDR32NB = 4'd8;
	localparam logic [3:0] MODE_TPOFF32  = 4'd9;
	localparam logic [3:0] MODE_B26      = 4'd10;
	localparam logic [3:0] MODE_ADRPG    = 4'd11;
	localparam logic [3:0] MODE_ADDLO    = 4'd12;
	localparam logic [3:0] MODE_GOTPG    = 4'd13;
	localparam logic [3:0] MODE_GOTLO    = 4'd14;

	// result status codes
	localparam logic [1:0] ST_PATCHED   = 2'd0;
	localparam logic [1:0] ST_NOCHANGE  = 2'd1;
	localparam logic [1:0] ST_UNHANDLED = 2'd2;

	// instruction field masks
	localparam logic [31:0] MASK_B26     = 32'h03ff_ffff;
	localparam logic [31:0] MASK_ADRP    = 32'h9f00_001f;
	localparam logic [31:0] MASK_IMM12   = 32'hffc0_03ff;
	localparam logic [18:0] MASK_IMMHI   = 19'h7_ffff;
	localparam logic [63:0] MASK_PAGEOFF = 64'h0000_0000_0000_0fff;

	localparam logic [63:0] LOAD_BASE_RST = 64'd0;

	typedef struct packed {
		logic [63:0] new_word;
		logic        write_eight;
		logic [1:0]  status;
	} rpu_res_t;

endpackage

[sv/rpu_in_if.sv]
interface rpu_in_if;
	logic               valid;
	logic               ready;
	logic [3:0]         mode;
	logic [63:0]        old_word;
	logic [63:0]        symbol_address;
	logic signed [63:0] addend;
	logic [63:0]        site_address;

	modport source (
		output valid, mode, old_word, symbol_address, addend, site_address,
		input  ready
	);
	modport sink (
		input  valid, mode, old_word, symbol_address, addend, site_address,
		output ready
	);
endinterface

[sv/rpu_out_if.sv]
interface rpu_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] new_word;
	logic        write_eight;
	logic [1:0]  status;

	modport source (
		output valid, new_word, write_eight, status,
		input  ready
	);
	modport sink (
		input  valid, new_word, write_eight, status,
		output ready
	);
endinterface

[sv/rpu_calc.sv]
module rpu_calc (
	input  logic [3:0]         mode,
	input  logic [63:0]        old_word,
	input  logic [63:0]        symbol_address,
	input  logic signed [63:0] addend,
	input  logic [63:0]        site_address,
	input  logic [63:0]        load_base,
	output rpu_pkg::rpu_res_t  res
);
	import rpu_pkg::*;

	logic [63:0] base_op;
	logic [63:0] sub_op;
	logic [63:0] neg_op;
	logic [63:0] s1, c1, s2, c2;
	logic [63:0] sum;
	logic [31:0] lo;

	assign lo = old_word[31:0];

	// operand select: old contents for data types, subtrahend per type
	always_comb begin
		base_op = old_word;
		sub_op  = 64'd0;
		unique case (mode)
			MODE_PC32, MODE_PC32PLT, MODE_GOTPCREL, MODE_PC64: sub_op = site_address;
			MODE_ADDR32NB: sub_op = load_base;
			MODE_B26: begin
				base_op = 64'd0;
				sub_op  = site_address;
			end
			MODE_ADRPG, MODE_GOTPG: begin
				base_op = 64'd0;
				sub_op  = site_address & ~MASK_PAGEOFF;
			end
			MODE_ADDLO, MODE_GOTLO: base_op = 64'd0;
			default: ;
		endcase
	end

	// two carry-save levels, then one carry-propagate add; the +1 of the
	// two's complement negate rides in the free low carry bit
	assign neg_op = ~sub_op;
	assign s1 = base_op ^ symbol_address ^ addend;
	assign c1 = {(base_op[62:0] & symbol_address[62:0]) |
		(base_op[62:0] & addend[62:0]) |
		(symbol_address[62:0] & addend[62:0]), 1'b0};
	assign s2 = s1 ^ c1 ^ neg_op;
	assign c2 = {(s1[62:0] & c1[62:0]) | (s1[62:0] & neg_op[62:0]) |
		(c1[62:0] & neg_op[62:0]), 1'b1};
	assign sum = s2 + c2;

	// insert the sum into the site word per type
	always_comb begin
		res.new_word    = old_word;
		res.write_eight = 1'b0;
		res.status      = ST_PATCHED;
		unique case (mode)
			MODE_NONE: begin
				res.write_eight = 1'b1;
				res.status      = ST_NOCHANGE;
			end
			MODE_ABS64, MODE_PC64: begin
				res.new_word    = sum;
				res.write_eight = 1'b1;
			end
			MODE_ABS32, MODE_ABS32U, MODE_TPOFF32, MODE_PC32, MODE_PC32PLT,
			MODE_GOTPCREL, MODE_ADDR32NB:
				res.new_word = {32'd0, sum[31:0]};
			MODE_B26:
				res.new_word = {32'd0, (lo & ~MASK_B26) | {6'd0, sum[27:2]}};
			MODE_ADRPG, MODE_GOTPG:
				res.new_word = {32'd0, (lo & MASK_ADRP) | {1'b0, sum[13:12], 29'd0} |
					{8'd0, sum[32:14] & MASK_IMMHI, 5'd0}};
			MODE_ADDLO:
				res.new_word = {32'd0, (lo & MASK_IMM12) | {10'd0, sum[11:0], 10'd0}};
			MODE_GOTLO:
				res.new_word = {32'd0, (lo & MASK_IMM12) | {13'd0, sum[11:3], 10'd0}};
			default: begin
				res.write_eight = 1'b1;
				res.status      = ST_UNHANDLED;
			end
		endcase
	end

endmodule

[sv/relocation_patch_unit.sv]
// An input beat is held in the input register, then in the result register.
// Throughput: one relocation per cycle while the output is not stalled; two carry-save
// levels feeding a single 64-bit adder sit between the two registers.
// Async reset (arst_n low): both stages empty, load base = LOAD_BASE_INIT, default 0.
// Input ready drops only when both stages hold a beat and the output is stalled.
module relocation_patch_unit #(
	parameter logic [63:0] LOAD_BASE_INIT = rpu_pkg::LOAD_BASE_RST
) (
	input  logic          clk,
	input  logic          arst_n,
	rpu_in_if.sink        in_ch,
	rpu_out_if.source     out_ch,
	input  logic          cfg_we,
	input  logic [63:0]   cfg_wdata
);
	import rpu_pkg::*;

	logic               valid_s1;
	logic [3:0]         mode_s1;
	logic [63:0]        old_word_s1;
	logic [63:0]        symbol_address_s1;
	logic signed [63:0] addend_s1;
	logic [63:0]        site_address_s1;
	logic               valid_s2;
	rpu_res_t           res_s2;
	rpu_res_t           res;
	logic [63:0]        load_base_q;
	logic               adv;

	// load base register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_base_q <= LOAD_BASE_INIT;
		end else if (cfg_we) begin
			load_base_q <= cfg_wdata;
		end
	end

	// stage handshake
	assign adv         = !valid_s2 || out_ch.ready;
	assign in_ch.ready = !valid_s1 || adv;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			mode_s1           <= in_ch.mode;
			old_word_s1       <= in_ch.old_word;
			symbol_address_s1 <= in_ch.symbol_address;
			addend_s1         <= in_ch.addend;
			site_address_s1   <= in_ch.site_address;
		end
	end

	rpu_calc u_calc (
		.mode           (mode_s1),
		.old_word       (old_word_s1),
		.symbol_address (symbol_address_s1),
		.addend         (addend_s1),
		.site_address   (site_address_s1),
		.load_base      (load_base_q),
		.res            (res)
	);

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			res_s2 <= res;
		end
	end

	assign out_ch.valid       = valid_s2;
	assign out_ch.new_word    = res_s2.new_word;
	assign out_ch.write_eight = res_s2.write_eight;
	assign out_ch.status      = res_s2.status;

	// a stalled beat in the input stage is kept
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !out_ch.ready) |=> valid_s1)
		else $error("input stage beat lost under stall");

	// a beat leaving the input stage lands in the result stage
	a_move: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv) |=> valid_s2)
		else $error("beat dropped between stages");

	// backpressure only when both stages are full and the output stalls
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> (valid_s1 && valid_s2 && !out_ch.ready))
		else $error("input stalled without cause");

	// non-patch results always report an eight-byte word
	a_nochg: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && (out_ch.status == ST_NOCHANGE || out_ch.status == ST_UNHANDLED))
		|-> out_ch.write_eight)
		else $error("no-change result with four-byte size");

endmodule
